// ----- rtl/core/imft_pkg.sv -----
// ----------------------------------------------------------------------------
// imft_pkg
// Shared types, codes and helpers of the masked IPv4 filter table.
// ----------------------------------------------------------------------------
package imft_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int ADDR_W   = 32;
    localparam int OCTETS_W = 4;
    localparam int SLOT_W   = 6;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // entry word: {value, octet enables, valid}
    localparam int ENTRY_W  = ADDR_W + OCTETS_W + 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
        logic load_out;
    } imft_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } imft_sts_t;

    function automatic logic [ADDR_W-1:0] expand_mask(input logic [OCTETS_W-1:0] octets);
        logic [ADDR_W-1:0] m;
        m = {{8{octets[3]}}, {8{octets[2]}}, {8{octets[1]}}, {8{octets[0]}}};
        return m;
    endfunction

endpackage

// ----- rtl/core/imft_ram.sv -----
// ----------------------------------------------------------------------------
// imft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/imft_ctrl.sv -----
// ----------------------------------------------------------------------------
// imft_ctrl
// Request sequencer: accept, scan the table, then hand the result over.
// ----------------------------------------------------------------------------
module imft_ctrl
    import imft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  imft_sts_t sts,
    output imft_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.start     = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_HOLD;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_HOLD:
            begin
                // wait for the output register to drain
                if (sts.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    in_ready_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ----- rtl/core/imft_dp.sv -----
// ----------------------------------------------------------------------------
// imft_dp
// Datapath: request registers, table memory, scan pointer, hit test,
// high-water count, mode register and output register.
// ----------------------------------------------------------------------------
module imft_dp
    import imft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  imft_cmd_t             cmd,
    output imft_sts_t             sts,
    input  logic [ACTION_W-1:0]   req_action,
    input  logic [ADDR_W-1:0]     req_address,
    input  logic [OCTETS_W-1:0]   req_octets,
    input  logic                  cfg_write,
    input  logic                  cfg_ban_mode,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [STATUS_W-1:0]   out_status,
    output logic                  out_matched,
    output logic                  out_rejected,
    output logic [SLOT_W-1:0]     out_slot
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // request
    logic [ACTION_W-1:0] act_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [OCTETS_W-1:0] oct_reg;

    // control state
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             ban_mode_reg;
    logic             out_valid_reg;

    // result staging and output payload
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_matched_reg;
    logic                res_rejected_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic                res_matched_next;
    logic                res_rejected_next;
    logic [SLOT_W-1:0]   res_slot_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_matched_reg;
    logic                out_rejected_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    // memory side
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    logic [ADDR_W-1:0]   ent_value;
    logic [OCTETS_W-1:0] ent_octets;
    logic                ent_valid;
    logic [ADDR_W-1:0]   req_cmp;
    logic                cond;
    logic                hit;
    logic                act_none;
    logic [IDX_W+SLOT_W-1:0] chk_wide;
    logic [IDX_W+SLOT_W-1:0] app_wide;
    logic [SLOT_W-1:0]   chk_slot;
    logic [SLOT_W-1:0]   app_slot;

    assign ent_value  = rd_data[ENTRY_W-1 -: ADDR_W];
    assign ent_octets = rd_data[OCTETS_W:1];
    assign ent_valid  = rd_data[0];
    assign req_cmp    = addr_reg & expand_mask(oct_reg);

    assign chk_wide = {{SLOT_W{1'b0}}, chk_idx_reg};
    assign app_wide = {{SLOT_W{1'b0}}, used_reg[IDX_W-1:0]};
    assign chk_slot = chk_wide[SLOT_W-1:0];
    assign app_slot = app_wide[SLOT_W-1:0];

    assign act_none = (act_reg != ACT_ADD) && (act_reg != ACT_REMOVE) &&
                      (act_reg != ACT_LOOKUP);

    always_comb
    begin
        unique case (act_reg)
            ACT_ADD:    cond = !ent_valid;
            ACT_REMOVE: cond = ent_valid && (ent_octets == oct_reg) &&
                               (ent_value == req_cmp);
            ACT_LOOKUP: cond = ent_valid &&
                               ((addr_reg & expand_mask(ent_octets)) == ent_value);
            default:    cond = 1'b0;
        endcase
    end

    assign hit = chk_vld_reg && cond;

    // done on a hit, on an unused action, or once every entry below the high-water count is checked
    assign sts.scan_done = act_none || hit || (!chk_vld_reg && (rd_idx_reg >= used_reg));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign rd_en = cmd.step && (rd_idx_reg < used_reg);

    always_comb
    begin
        wr_en             = 1'b0;
        wr_idx            = chk_idx_reg;
        wr_data           = {req_cmp, oct_reg, 1'b1};
        used_next         = used_reg;
        res_status_next   = STS_OK;
        res_matched_next  = 1'b0;
        res_rejected_next = 1'b0;
        res_slot_next     = '0;
        if (cmd.finish)
        begin
            unique case (act_reg)
                ACT_ADD:
                begin
                    if (hit)
                    begin
                        wr_en         = 1'b1;
                        res_slot_next = chk_slot;
                    end
                    else if (used_reg < DEPTH_CNT)
                    begin
                        // append at the high-water mark
                        wr_en         = 1'b1;
                        wr_idx        = used_reg[IDX_W-1:0];
                        used_next     = used_reg + CNT_W'(1);
                        res_slot_next = app_slot;
                    end
                    else
                    begin
                        res_status_next = STS_FULL;
                    end
                end
                ACT_REMOVE:
                begin
                    if (hit)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = {ent_value, ent_octets, 1'b0};
                        res_slot_next = chk_slot;
                    end
                    else
                    begin
                        res_status_next = STS_NOT_FOUND;
                    end
                end
                ACT_LOOKUP:
                begin
                    res_matched_next  = hit;
                    res_rejected_next = ban_mode_reg ? hit : !hit;
                    res_slot_next     = hit ? chk_slot : '0;
                end
                default:
                begin
                    res_status_next = STS_OK;
                end
            endcase
        end
    end

    imft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rd_idx_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            ban_mode_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (cfg_write)
            begin
                ban_mode_reg <= cfg_ban_mode;
            end
            if (cmd.start)
            begin
                rd_idx_reg  <= '0;
                chk_vld_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                chk_vld_reg <= rd_en;
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            act_reg  <= req_action;
            addr_reg <= req_address;
            oct_reg  <= req_octets;
        end
        if (cmd.step)
        begin
            chk_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.finish)
        begin
            res_status_reg   <= res_status_next;
            res_matched_reg  <= res_matched_next;
            res_rejected_reg <= res_rejected_next;
            res_slot_reg     <= res_slot_next;
        end
        if (cmd.load_out)
        begin
            out_status_reg   <= res_status_reg;
            out_matched_reg  <= res_matched_reg;
            out_rejected_reg <= res_rejected_reg;
            out_slot_reg     <= res_slot_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_matched  = out_matched_reg;
    assign out_rejected = out_rejected_reg;
    assign out_slot     = out_slot_reg;

endmodule

// ----- rtl/core/ip_masked_filter_table_unit.sv -----
// ----------------------------------------------------------------------------
// ip_masked_filter_table_unit
// Table of IPv4 filters with per-octet wildcards: add, remove and look up.
//
//   channel  direction  signals                      contents
//   s_*      in         tvalid tready tdata tuser    request: action, address, mask
//   m_*      out        tvalid tready tdata          result: status, flags, slot
//   cfg_*    in         valid ready data             ban_mode register
//
// The scan reads one entry a cycle through the single RAM read port and checks
// it in the next cycle; a hit ends the scan at once, a miss ends it once the
// last entry is checked. The result is staged at the end of the scan and moves
// into the output register once that register is free. Reset empties the table
// at once through the high-water count. A stalled result waits in the output
// register; the next request is accepted meanwhile and its result is held until
// that register drains.
// ----------------------------------------------------------------------------
module ip_masked_filter_table_unit
    import imft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // address[31:0], octet_mask[35:32], zero
    input  logic [ACTION_W-1:0]  s_tuser,  // action[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // status[1:0], matched[2], rejected[3],
                                           // slot[9:4], zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data  // ban_mode
);

    imft_cmd_t           cmd;
    imft_sts_t           sts;
    logic [STATUS_W-1:0] status;
    logic                matched;
    logic                rejected;
    logic [SLOT_W-1:0]   slot;

    assign cfg_ready = 1'b1;

    imft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    imft_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_action   (s_tuser),
        .req_address  (s_tdata[ADDR_W-1:0]),
        .req_octets   (s_tdata[ADDR_W+OCTETS_W-1:ADDR_W]),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_ban_mode (cfg_data),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (status),
        .out_matched  (matched),
        .out_rejected (rejected),
        .out_slot     (slot)
    );

    assign m_tdata = {{(M_TDATA_W - STATUS_W - 2 - SLOT_W){1'b0}},
                      slot, rejected, matched, status};

endmodule

// ----- test/imft_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imft_checker
// Watches the request, result and ban_mode channels of the filter table,
// keeps its own copy of the table and compares each result field by field.
// ----------------------------------------------------------------------------
module imft_checker
    import imft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // address[31:0], octet_mask[35:32], zero
    input  logic [ACTION_W-1:0]  s_tuser,  // action[1:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // status[1:0], matched[2], rejected[3],
                                           // slot[9:4], zero
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_data,  // ban_mode
    output int                   fail_count,
    output int                   outstanding,
    output int                   full_reports
);

    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                matched;
        logic                rejected;
        logic [SLOT_W-1:0]   slot;
    } verdict_t;

    logic [ADDR_W-1:0]   table_value [DEPTH];
    logic [OCTETS_W-1:0] table_octets [DEPTH];
    logic                table_live [DEPTH];
    int                  high_water;
    logic                ban_q;

    verdict_t verdicts_due[$];
    verdict_t got;
    verdict_t want;
    int       errors = 0;
    int       fulls = 0;
    int       k;

    function automatic logic [ADDR_W-1:0] octet_bits(input logic [OCTETS_W-1:0] octs);
        logic [ADDR_W-1:0] m;
        int j;
        m = '0;
        for (j = 0; j < 4; j++)
            if (octs[j])
                m[8*j +: 8] = 8'hff;
        return m;
    endfunction

    // Apply one request to the shadow table and return the answer it earns.
    function automatic verdict_t apply_request(input logic [ACTION_W-1:0] act,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [OCTETS_W-1:0] octs);
        verdict_t v;
        int span;
        int hit;
        int j;
        logic [ADDR_W-1:0] cmp;
        v = '0;
        span = (high_water > DEPTH) ? DEPTH : high_water;
        hit = -1;
        case (act)
            ACT_ADD:
            begin
                for (j = 0; j < span; j++)
                    if (!table_live[j] && hit < 0)
                        hit = j;
                if (hit < 0 && span < DEPTH)
                begin
                    hit = span;
                    high_water = span + 1;
                end
                if (hit < 0)
                    v.status = STS_FULL;
                else
                begin
                    table_value[hit]  = addr & octet_bits(octs);
                    table_octets[hit] = octs;
                    table_live[hit]   = 1'b1;
                    v.slot = hit[SLOT_W-1:0];
                end
            end
            ACT_REMOVE:
            begin
                cmp = addr & octet_bits(octs);
                v.status = STS_NOT_FOUND;
                for (j = 0; j < span; j++)
                    if (hit < 0 && table_live[j] && table_octets[j] == octs
                        && table_value[j] == cmp)
                        hit = j;
                if (hit >= 0)
                begin
                    table_live[hit] = 1'b0;
                    v.status = STS_OK;
                    v.slot = hit[SLOT_W-1:0];
                end
            end
            ACT_LOOKUP:
            begin
                for (j = 0; j < span; j++)
                    if (hit < 0 && table_live[j]
                        && (addr & octet_bits(table_octets[j])) == table_value[j])
                        hit = j;
                if (hit >= 0)
                begin
                    v.matched = 1'b1;
                    v.slot = hit[SLOT_W-1:0];
                end
                v.rejected = ban_q ? v.matched : !v.matched;
            end
            default:
                v = '0;
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < DEPTH; k++)
            begin
                table_value[k]  = '0;
                table_octets[k] = '0;
                table_live[k]   = 1'b0;
            end
            high_water = 0;
            ban_q = 1'b1;
            verdicts_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                ban_q = cfg_data;
            // Compare first: a result leaving now belongs to an earlier request.
            if (m_tvalid && m_tready)
            begin
                got.status   = m_tdata[1:0];
                got.matched  = m_tdata[2];
                got.rejected = m_tdata[3];
                got.slot     = m_tdata[9:4];
                if (got.status == STS_FULL)
                    fulls++;
                if (verdicts_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with none due: st=%0d m=%0d r=%0d slot=%0d",
                                 $realtime, got.status, got.matched, got.rejected,
                                 got.slot);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got.status != want.status || got.matched != want.matched
                        || got.rejected != want.rejected || got.slot != want.slot)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch, expected st=%0d m=%0d r=%0d slot=%0d",
                                     $realtime, want.status, want.matched,
                                     want.rejected, want.slot);
                            $display("    got st=%0d m=%0d r=%0d slot=%0d",
                                     got.status, got.matched, got.rejected, got.slot);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                verdicts_due.push_back(apply_request(s_tuser, s_tdata[31:0],
                                                     s_tdata[35:32]));
        end
        fail_count   <= errors;
        outstanding  <= verdicts_due.size();
        full_reports <= fulls;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add, remove and lookup requests into the masked filter table under
// both ban_mode settings and four idle/stall patterns; the checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import imft_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 225;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [OCTETS_W-1:0] octets;
        logic [ADDR_W-1:0]   value;
    } filter_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [ACTION_W-1:0]  s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;

    int fail_count;
    int outstanding;
    int full_reports;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_add = 0;
    int n_remove = 0;
    int n_lookup = 0;
    int n_unused = 0;
    int ph;
    int n;

    int      idle_by_phase [4] = '{0, 79, 0, 32};
    int      stall_by_phase [4] = '{0, 0, 79, 32};
    filter_t known_filters[$];

    ip_masked_filter_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    imft_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .full_reports (full_reports)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

    // Returns at the edge that takes the request.
    task automatic issue_request(input logic [ACTION_W-1:0] act,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [OCTETS_W-1:0] octs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, octs, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (act)
            ACT_ADD:    n_add++;
            ACT_REMOVE: n_remove++;
            ACT_LOOKUP: n_lookup++;
            default:    n_unused++;
        endcase
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_ban_mode(input logic mode);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Bias octets towards 0 and 255 so that filters collide now and then.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        int j;
        a = $urandom();
        if ($urandom_range(1) == 1)
            for (j = 0; j < 4; j++)
                case ($urandom_range(3))
                    0:       a[8*j +: 8] = 8'h00;
                    1:       a[8*j +: 8] = 8'hff;
                    default: a[8*j +: 8] = a[8*j +: 8];
                endcase
        return a;
    endfunction

    // Refill wildcard octets of a stored filter with noise; it still matches.
    function automatic logic [ADDR_W-1:0] scramble_wildcards(input filter_t f);
        logic [ADDR_W-1:0] a;
        int j;
        a = f.value;
        for (j = 0; j < 4; j++)
            if (!f.octets[j])
                a[8*j +: 8] = 8'($urandom_range(255));
        return a;
    endfunction

    task automatic random_request(input bit filling);
        int r;
        int idx;
        filter_t f;
        logic [ADDR_W-1:0] a;
        logic [OCTETS_W-1:0] o;
        r = $urandom_range(99);
        if (r < (filling ? 70 : 15))
        begin
            a = pick_address();
            o = OCTETS_W'($urandom_range(15));
            issue_request(ACT_ADD, a, o);
            if (known_filters.size() < TABLE_DEPTH_DEF)
                known_filters.push_back({o, a});
        end
        else if (r < (filling ? 75 : 65))
        begin
            if (known_filters.size() != 0 && $urandom_range(3) != 0)
            begin
                idx = $urandom_range(known_filters.size() - 1);
                f = known_filters[idx];
                known_filters.delete(idx);
                issue_request(ACT_REMOVE, scramble_wildcards(f), f.octets);
            end
            else
                issue_request(ACT_REMOVE, pick_address(), OCTETS_W'($urandom_range(15)));
        end
        else if (r < 95)
        begin
            if (known_filters.size() != 0 && $urandom_range(9) < 7)
            begin
                f = known_filters[$urandom_range(known_filters.size() - 1)];
                a = scramble_wildcards(f);
            end
            else
                a = pick_address();
            issue_request(ACT_LOOKUP, a, OCTETS_W'($urandom_range(15)));
        end
        else
            issue_request(ACT_UNUSED, pick_address(), OCTETS_W'($urandom_range(15)));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_ban_mode(1'b1);
        issue_request(ACT_LOOKUP, 32'h0000_0000, 4'hf);   // empty table
        issue_request(ACT_ADD, 32'hffff_ffff, 4'hf);
        issue_request(ACT_ADD, 32'hffff_ffff, 4'h0);      // all wildcard, stored as zero
        issue_request(ACT_ADD, 32'hc0a8_01ff, 4'he);      // last octet dropped
        issue_request(ACT_LOOKUP, 32'hffff_ffff, 4'h0);
        issue_request(ACT_LOOKUP, 32'h1234_5678, 4'hf);
        issue_request(ACT_REMOVE, 32'h0000_0000, 4'h0);   // frees slot 1
        issue_request(ACT_REMOVE, 32'h0000_0000, 4'h0);   // miss
        issue_request(ACT_LOOKUP, 32'hc0a8_01fe, 4'h0);
        issue_request(ACT_LOOKUP, 32'h1234_5678, 4'h0);
        issue_request(ACT_ADD, 32'hc0a8_0177, 4'he);      // reuses the freed slot
        issue_request(ACT_REMOVE, 32'hc0a8_01aa, 4'hf);   // mask differs: miss
        issue_request(ACT_REMOVE, 32'hc0a8_01aa, 4'he);   // first duplicate goes
        issue_request(ACT_UNUSED, 32'hffff_ffff, 4'hf);
        issue_request(ACT_LOOKUP, 32'hc0a8_0105, 4'h0);
        write_ban_mode(1'b0);
        issue_request(ACT_LOOKUP, 32'hffff_ffff, 4'h0);
        issue_request(ACT_LOOKUP, 32'h0102_0304, 4'h0);
        issue_request(ACT_ADD, 32'h0000_0000, 4'hf);
        issue_request(ACT_LOOKUP, 32'h0000_0000, 4'h0);

        known_filters.push_back({4'hf, 32'hffff_ffff});
        known_filters.push_back({4'he, 32'hc0a8_0100});
        known_filters.push_back({4'hf, 32'h0000_0000});

        for (ph = 0; ph < 4; ph++)
        begin
            write_ban_mode(ph[0] ? 1'b0 : 1'b1);
            send_idle_pct  = idle_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off the sender until the block has answered everything.
                if (n == 100)
                    wait_results_drained();
                random_request(n < PHASE_ITEMS / 2);
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d adds, %0d removes, %0d lookups and %0d unused-code requests,",
                 n_add, n_remove, n_lookup, n_unused);
        $display("ban and allow mode, four idle/stall patterns, %0d table-full answers.",
                 full_reports);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/imft_pkg.sv
rtl/core/imft_ram.sv
rtl/core/imft_ctrl.sv
rtl/core/imft_dp.sv
rtl/core/ip_masked_filter_table_unit.sv
test/imft_checker.sv
test/tb_top.sv
